// File: design/fully_assoc_tlb_pointer_replace_top_assert.svh
// assertion macros for the tlb checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef FULLY_ASSOC_TLB_POINTER_REPLACE_TOP_ASSERT_SVH
`define FULLY_ASSOC_TLB_POINTER_REPLACE_TOP_ASSERT_SVH

// checked on every rising edge outside reset
`define FATLB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tlb check failed");

// checked on every rising edge, reset included
`define FATLB_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("tlb check failed");

`endif

// File: design/fatlb_pkg.sv
// shared types and constants for the fully associative tlb
// no dependencies
package fatlb_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int KIND_W  = 2;
    localparam int PAGE_W  = 8;
    localparam int FRAME_W = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEARCH = 2'd0,
        KIND_FILL   = 2'd1,
        KIND_REMAP  = 2'd2,
        KIND_FLUSH  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVICT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

endpackage

// File: design/fatlb_mem.sv
// entry store: page and frame pairs, one write and one registered read per cycle
// depends on fatlb_pkg
module fatlb_mem
    import fatlb_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rdata
);

    t_entry r_mem [ENTRIES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/fully_assoc_tlb_pointer_replace_top.sv
// channel | direction | handshake          | payload
// input   | in        | i_valid / o_stall  | i_kind i_page i_new_frame i_old_page i_old_frame
// output  | out       | o_valid / i_stall  | o_hit o_frame_out o_l1_install o_install_page
//         |           |                    | o_evicted o_evicted_frame o_evicted_page
//
// one item at a time; search and remap read one entry per cycle from the entry store,
// so their result is ready once a matching entry is read or the last slot is checked
// fill into a free slot and flush go straight to the result; fill into a full table evicts first
// the next transfer in is taken only after the result has moved into the output register
// reset clears all valid bits and the replacement pointer at once, no clearing pass
// a finished result waits in the output register while i_stall is high
// depends on fatlb_pkg and fatlb_mem
module fully_assoc_tlb_pointer_replace_top
    import fatlb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [PAGE_W-1:0]  i_page,
    input  logic [FRAME_W-1:0] i_new_frame,
    input  logic [PAGE_W-1:0]  i_old_page,
    input  logic [FRAME_W-1:0] i_old_frame,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_hit,
    output logic [FRAME_W-1:0] o_frame_out,
    output logic               o_l1_install,
    output logic [PAGE_W-1:0]  o_install_page,
    output logic               o_evicted,
    output logic [FRAME_W-1:0] o_evicted_frame,
    output logic [PAGE_W-1:0]  o_evicted_page
);

    localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

    t_state              r_state, n_state;
    logic [ENTRIES-1:0]  r_valid, n_valid;
    logic [IDX_W-1:0]    r_ptr, n_ptr;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_out_vld, n_out_vld;

    t_kind               r_kind, n_kind;
    logic [PAGE_W-1:0]   r_page, n_page;
    logic [FRAME_W-1:0]  r_new_frame, n_new_frame;
    logic [PAGE_W-1:0]   r_old_page, n_old_page;
    logic [FRAME_W-1:0]  r_old_frame, n_old_frame;

    logic                r_res_hit, n_res_hit;
    logic [FRAME_W-1:0]  r_res_frame, n_res_frame;
    logic                r_res_inst, n_res_inst;
    logic [PAGE_W-1:0]   r_res_ipage, n_res_ipage;
    logic                r_res_evict, n_res_evict;
    logic [FRAME_W-1:0]  r_res_eframe, n_res_eframe;
    logic [PAGE_W-1:0]   r_res_epage, n_res_epage;

    logic                r_out_hit, n_out_hit;
    logic [FRAME_W-1:0]  r_out_frame, n_out_frame;
    logic                r_out_inst, n_out_inst;
    logic [PAGE_W-1:0]   r_out_ipage, n_out_ipage;
    logic                r_out_evict, n_out_evict;
    logic [FRAME_W-1:0]  r_out_eframe, n_out_eframe;
    logic [PAGE_W-1:0]   r_out_epage, n_out_epage;

    t_mem_req            mem_req;
    t_entry              mem_rdata;
    logic                in_xfer;
    logic                out_free;
    logic [IDX_W-1:0]    free_idx;
    logic [IDX_W-1:0]    evict_idx;
    logic [IDX_W-1:0]    next_idx;
    logic [PAGE_W-1:0]   cmp_page;
    logic                scan_match;

    fatlb_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign o_stall  = (r_state != ST_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    assign out_free = !r_out_vld || !i_stall;

    // lowest invalid slot
    always_comb begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign evict_idx  = (r_ptr == LAST) ? '0 : r_ptr + IDX_W'(1);
    assign next_idx   = (r_idx == LAST) ? '0 : r_idx + IDX_W'(1);
    assign cmp_page   = (r_kind == KIND_SEARCH) ? r_page : r_old_page;
    assign scan_match = r_valid[r_idx] && (mem_rdata.page == cmp_page) &&
                        ((r_kind == KIND_SEARCH) || (mem_rdata.frame == r_old_frame));

    always_comb begin
        n_state      = r_state;
        n_valid      = r_valid;
        n_ptr        = r_ptr;
        n_idx        = r_idx;
        n_kind       = r_kind;
        n_page       = r_page;
        n_new_frame  = r_new_frame;
        n_old_page   = r_old_page;
        n_old_frame  = r_old_frame;
        n_res_hit    = r_res_hit;
        n_res_frame  = r_res_frame;
        n_res_inst   = r_res_inst;
        n_res_ipage  = r_res_ipage;
        n_res_evict  = r_res_evict;
        n_res_eframe = r_res_eframe;
        n_res_epage  = r_res_epage;
        n_out_hit    = r_out_hit;
        n_out_frame  = r_out_frame;
        n_out_inst   = r_out_inst;
        n_out_ipage  = r_out_ipage;
        n_out_evict  = r_out_evict;
        n_out_eframe = r_out_eframe;
        n_out_epage  = r_out_epage;
        n_out_vld    = r_out_vld;

        mem_req.we         = 1'b0;
        mem_req.waddr      = r_idx;
        mem_req.wdata.page = r_page;
        mem_req.wdata.frame = r_new_frame;
        mem_req.raddr      = next_idx;

        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                mem_req.raddr = '0;
                if (in_xfer) begin
                    n_kind       = t_kind'(i_kind);
                    n_page       = i_page;
                    n_new_frame  = i_new_frame;
                    n_old_page   = i_old_page;
                    n_old_frame  = i_old_frame;
                    n_idx        = '0;
                    n_res_hit    = 1'b0;
                    n_res_frame  = '0;
                    n_res_inst   = 1'b0;
                    n_res_ipage  = '0;
                    n_res_evict  = 1'b0;
                    n_res_eframe = '0;
                    n_res_epage  = '0;
                    unique case (t_kind'(i_kind))
                        KIND_SEARCH, KIND_REMAP: begin
                            n_state = ST_SCAN;
                        end
                        KIND_FILL: begin
                            if (&r_valid) begin
                                mem_req.raddr = evict_idx;
                                n_idx         = evict_idx;
                                n_state       = ST_EVICT;
                            end else begin
                                mem_req.we          = 1'b1;
                                mem_req.waddr       = free_idx;
                                mem_req.wdata.page  = i_page;
                                mem_req.wdata.frame = i_new_frame;
                                n_valid[free_idx]   = 1'b1;
                                n_state             = ST_DONE;
                            end
                        end
                        KIND_FLUSH: begin
                            n_valid = '0;
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_match) begin
                    n_ptr     = r_idx;
                    n_res_hit = 1'b1;
                    if (r_kind == KIND_SEARCH) begin
                        n_res_frame = mem_rdata.frame;
                        n_res_inst  = 1'b1;
                        n_res_ipage = mem_rdata.page;
                    end else begin
                        mem_req.we = 1'b1;
                    end
                    n_state = ST_DONE;
                end else if (r_idx == LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = next_idx;
                end
            end
            ST_EVICT: begin
                n_res_evict    = 1'b1;
                n_res_eframe   = mem_rdata.frame;
                n_res_epage    = mem_rdata.page;
                mem_req.we     = 1'b1;
                n_valid[r_idx] = 1'b1;
                n_state        = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_hit    = r_res_hit;
                    n_out_frame  = r_res_frame;
                    n_out_inst   = r_res_inst;
                    n_out_ipage  = r_res_ipage;
                    n_out_evict  = r_res_evict;
                    n_out_eframe = r_res_eframe;
                    n_out_epage  = r_res_epage;
                    n_state      = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_ptr     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_ptr     <= n_ptr;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_kind       <= n_kind;
        r_page       <= n_page;
        r_new_frame  <= n_new_frame;
        r_old_page   <= n_old_page;
        r_old_frame  <= n_old_frame;
        r_res_hit    <= n_res_hit;
        r_res_frame  <= n_res_frame;
        r_res_inst   <= n_res_inst;
        r_res_ipage  <= n_res_ipage;
        r_res_evict  <= n_res_evict;
        r_res_eframe <= n_res_eframe;
        r_res_epage  <= n_res_epage;
        r_out_hit    <= n_out_hit;
        r_out_frame  <= n_out_frame;
        r_out_inst   <= n_out_inst;
        r_out_ipage  <= n_out_ipage;
        r_out_evict  <= n_out_evict;
        r_out_eframe <= n_out_eframe;
        r_out_epage  <= n_out_epage;
    end

    assign o_valid         = r_out_vld;
    assign o_hit           = r_out_hit;
    assign o_frame_out     = r_out_frame;
    assign o_l1_install    = r_out_inst;
    assign o_install_page  = r_out_ipage;
    assign o_evicted       = r_out_evict;
    assign o_evicted_frame = r_out_eframe;
    assign o_evicted_page  = r_out_epage;

endmodule

// File: design/fatlb_chk.sv
// port level checks for the tlb top level, attached by bind
// depends on fatlb_pkg and fully_assoc_tlb_pointer_replace_top_assert.svh
`include "fully_assoc_tlb_pointer_replace_top_assert.svh"

module fatlb_chk
    import fatlb_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_hit,
    input logic [FRAME_W-1:0] o_frame_out,
    input logic               o_l1_install,
    input logic               o_evicted
);

    // a result waiting on a stalled receiver stays offered
    `FATLB_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid)

    // one item at a time: an input transfer closes the input side
    `FATLB_ASSERT(a_one_item, i_valid && !o_stall |=> o_stall)

    // install request only on a search hit
    `FATLB_ASSERT(a_install_hit, o_valid && o_l1_install |-> o_hit)

    // an eviction never reports a hit, and no hit means no frame
    `FATLB_ASSERT(a_evict_nohit,
        o_valid |-> !(o_evicted && o_hit) && (o_hit || (o_frame_out == '0)))

endmodule

bind fully_assoc_tlb_pointer_replace_top fatlb_chk u_fatlb_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_hit        (o_hit),
    .o_frame_out  (o_frame_out),
    .o_l1_install (o_l1_install),
    .o_evicted    (o_evicted)
);

// File: sim/tlb_translation_checker.sv
// watches both channels of the tlb, predicts each result from its own copy of the table
// and compares every output transfer against the oldest prediction
// depends on fatlb_pkg
module tlb_translation_checker
    import fatlb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [PAGE_W-1:0]  i_page,
    input  logic [FRAME_W-1:0] i_new_frame,
    input  logic [PAGE_W-1:0]  i_old_page,
    input  logic [FRAME_W-1:0] i_old_frame,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_hit,
    input  logic [FRAME_W-1:0] i_frame_out,
    input  logic               i_l1_install,
    input  logic [PAGE_W-1:0]  i_install_page,
    input  logic               i_evicted,
    input  logic [FRAME_W-1:0] i_evicted_frame,
    input  logic [PAGE_W-1:0]  i_evicted_page,
    output int                 o_mismatch_count,
    output int                 o_outstanding
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_out;
        logic               l1_install;
        logic [PAGE_W-1:0]  install_page;
        logic               evicted;
        logic [FRAME_W-1:0] evicted_frame;
        logic [PAGE_W-1:0]  evicted_page;
    } t_tlb_answer;

    logic               slot_valid [ENTRIES];
    logic [PAGE_W-1:0]  slot_page  [ENTRIES];
    logic [FRAME_W-1:0] slot_frame [ENTRIES];
    int                 victim_ptr;
    t_tlb_answer        expected_answers [$];
    int                 mismatches = 0;

    function automatic t_tlb_answer predict_tlb_op(
        t_kind              kind,
        logic [PAGE_W-1:0]  page,
        logic [FRAME_W-1:0] new_frame,
        logic [PAGE_W-1:0]  old_page,
        logic [FRAME_W-1:0] old_frame
    );
        t_tlb_answer ans;
        int          i;
        int          slot;
        ans  = '0;
        slot = -1;
        case (kind)
            KIND_SEARCH: begin
                for (i = 0; i < ENTRIES; i++) begin
                    if (slot < 0 && slot_valid[i] && slot_page[i] == page) begin
                        slot = i;
                    end
                end
                if (slot >= 0) begin
                    victim_ptr       = slot;
                    ans.hit          = 1'b1;
                    ans.frame_out    = slot_frame[slot];
                    ans.l1_install   = 1'b1;
                    ans.install_page = slot_page[slot];
                end
            end
            KIND_FILL: begin
                for (i = 0; i < ENTRIES; i++) begin
                    if (slot < 0 && !slot_valid[i]) begin
                        slot = i;
                    end
                end
                if (slot < 0) begin
                    // table full: replace the slot after the pointer
                    slot              = (victim_ptr + 1) % ENTRIES;
                    ans.evicted       = 1'b1;
                    ans.evicted_frame = slot_frame[slot];
                    ans.evicted_page  = slot_page[slot];
                end
                slot_valid[slot] = 1'b1;
                slot_page[slot]  = page;
                slot_frame[slot] = new_frame;
            end
            KIND_REMAP: begin
                for (i = 0; i < ENTRIES; i++) begin
                    if (slot < 0 && slot_valid[i] && slot_page[i] == old_page &&
                            slot_frame[i] == old_frame) begin
                        slot = i;
                    end
                end
                if (slot >= 0) begin
                    victim_ptr       = slot;
                    slot_page[slot]  = page;
                    slot_frame[slot] = new_frame;
                    ans.hit          = 1'b1;
                end
            end
            KIND_FLUSH: begin
                for (i = 0; i < ENTRIES; i++) begin
                    slot_valid[i] = 1'b0;
                end
            end
        endcase
        return ans;
    endfunction

    function automatic string answer_text(t_tlb_answer a);
        return $sformatf("hit=%0b frame=%h l1=%0b ipage=%h ev=%0b evframe=%h evpage=%h",
            a.hit, a.frame_out, a.l1_install, a.install_page,
            a.evicted, a.evicted_frame, a.evicted_page);
    endfunction

    always @(posedge i_clk) begin : watch
        t_tlb_answer seen;
        t_tlb_answer want;
        int          i;
        if (!i_rst_n) begin
            for (i = 0; i < ENTRIES; i++) begin
                slot_valid[i] = 1'b0;
                slot_page[i]  = '0;
                slot_frame[i] = '0;
            end
            victim_ptr = 0;
            expected_answers.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                seen = '{i_hit, i_frame_out, i_l1_install, i_install_page,
                         i_evicted, i_evicted_frame, i_evicted_page};
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("tlb result with nothing expected: %s", answer_text(seen));
                    end
                end else begin
                    want = expected_answers.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("tlb result mismatch: expected %s", answer_text(want));
                            $display("                     actual   %s", answer_text(seen));
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_answers.push_back(predict_tlb_op(t_kind'(i_kind), i_page,
                    i_new_frame, i_old_page, i_old_frame));
            end
        end
        o_mismatch_count <= mismatches;
        o_outstanding    <= expected_answers.size();
    end

endmodule

// File: sim/tb_fully_assoc_tlb_pointer_replace_top.sv
// testbench top for the fully associative tlb: clock, reset, directed and random
// operation sequences with random idling on both channels, and the final verdict
// depends on fatlb_pkg, fully_assoc_tlb_pointer_replace_top and tlb_translation_checker
module tb_fully_assoc_tlb_pointer_replace_top
    import fatlb_pkg::*;
();

    localparam int CLK_PERIOD = 8;
    localparam int TOTAL_OPS  = 1750;
    localparam int QUIET_OPS  = 150;
    localparam int PAIR_DEPTH = 24;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_valid         = 1'b0;
    logic               o_stall;
    logic [KIND_W-1:0]  i_kind          = KIND_SEARCH;
    logic [PAGE_W-1:0]  i_page          = '0;
    logic [FRAME_W-1:0] i_new_frame     = '0;
    logic [PAGE_W-1:0]  i_old_page      = '0;
    logic [FRAME_W-1:0] i_old_frame     = '0;
    logic               o_valid;
    logic               i_stall         = 1'b0;
    logic               o_hit;
    logic [FRAME_W-1:0] o_frame_out;
    logic               o_l1_install;
    logic [PAGE_W-1:0]  o_install_page;
    logic               o_evicted;
    logic [FRAME_W-1:0] o_evicted_frame;
    logic [PAGE_W-1:0]  o_evicted_page;

    int     mismatch_count;
    int     outstanding;
    int     sent_ops    = 0;
    logic   tail_quiet  = 1'b0;
    logic   calm_input  = 1'b0;
    t_entry known_pairs [$];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    fully_assoc_tlb_pointer_replace_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_page          (i_page),
        .i_new_frame     (i_new_frame),
        .i_old_page      (i_old_page),
        .i_old_frame     (i_old_frame),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hit           (o_hit),
        .o_frame_out     (o_frame_out),
        .o_l1_install    (o_l1_install),
        .o_install_page  (o_install_page),
        .o_evicted       (o_evicted),
        .o_evicted_frame (o_evicted_frame),
        .o_evicted_page  (o_evicted_page)
    );

    tlb_translation_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_kind           (i_kind),
        .i_page           (i_page),
        .i_new_frame      (i_new_frame),
        .i_old_page       (i_old_page),
        .i_old_frame      (i_old_frame),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_hit            (o_hit),
        .i_frame_out      (o_frame_out),
        .i_l1_install     (o_l1_install),
        .i_install_page   (o_install_page),
        .i_evicted        (o_evicted),
        .i_evicted_frame  (o_evicted_frame),
        .i_evicted_page   (o_evicted_page),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    task automatic send_op(
        t_kind              kind,
        logic [PAGE_W-1:0]  page,
        logic [FRAME_W-1:0] new_frame,
        logic [PAGE_W-1:0]  old_page,
        logic [FRAME_W-1:0] old_frame
    );
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_page      <= page;
        i_new_frame <= new_frame;
        i_old_page  <= old_page;
        i_old_frame <= old_frame;
        @(posedge i_clk iff !o_stall);
        sent_ops++;
        tail_quiet = (sent_ops >= TOTAL_OPS - QUIET_OPS);
        if (!tail_quiet && !calm_input && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic remember_pair(logic [PAGE_W-1:0] page, logic [FRAME_W-1:0] frame);
        known_pairs.push_back('{page: page, frame: frame});
        if (known_pairs.size() > PAIR_DEPTH) begin
            void'(known_pairs.pop_front());
        end
    endtask

    // output side back-pressure, alternating busy and calm stretches
    initial begin
        int   phase_len;
        logic busy;
        forever begin
            phase_len = $urandom_range(50, 300);
            busy      = ($urandom_range(0, 2) != 0);
            repeat (phase_len) begin
                @(posedge i_clk);
                if (busy && !tail_quiet && $urandom_range(0, 7) == 0) begin
                    i_stall <= 1'b1;
                    repeat ($urandom_range(1, 18)) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
        end
    end

    initial begin
        #(CLK_PERIOD * 600000);
        $display("FAILURE");
        $finish;
    end

    initial begin
        int                 s;
        int                 roll;
        int                 pool_base;
        logic [PAGE_W-1:0]  pg;
        logic [FRAME_W-1:0] fr;
        t_entry             pr;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: search and remap both miss
        send_op(KIND_SEARCH, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_op(KIND_REMAP, 8'h00, 16'h0000, 8'hFF, 16'hFFFF);
        // fill every slot, extremes at both ends and a duplicate page in slot 7
        for (s = 0; s < ENTRIES; s++) begin
            pg = (s == 0) ? 8'h00 : (s == ENTRIES - 1) ? 8'hFF :
                 (s == 7) ? PAGE_W'(3 * 13) : PAGE_W'(s * 13);
            fr = (s == 0) ? 16'h0000 : (s == ENTRIES - 1) ? 16'hFFFF : FRAME_W'(s * 4099);
            send_op(KIND_FILL, pg, fr, ~pg, ~fr);
        end
        send_op(KIND_SEARCH, 8'hFF, 16'h0000, 8'h00, 16'h0000);
        send_op(KIND_FILL, 8'hAA, 16'h5555, 8'h00, 16'h0000);
        send_op(KIND_FILL, 8'hAB, 16'hAAAA, 8'hFF, 16'hFFFF);
        send_op(KIND_REMAP, 8'h55, 16'h1234, PAGE_W'(3 * 13), FRAME_W'(3 * 4099));
        send_op(KIND_SEARCH, PAGE_W'(3 * 13), 16'hFFFF, 8'hFF, 16'h0000);
        send_op(KIND_REMAP, 8'h01, 16'h0001, 8'h55, 16'h1235);
        send_op(KIND_FILL, 8'h12, 16'h3456, 8'h00, 16'hFFFF);
        send_op(KIND_FLUSH, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_op(KIND_SEARCH, 8'hAB, 16'h0000, 8'h00, 16'h0000);
        send_op(KIND_FILL, 8'h80, 16'h8000, 8'h00, 16'h0000);

        while (sent_ops < TOTAL_OPS) begin
            calm_input = ($urandom_range(0, 3) == 0);
            pool_base  = $urandom_range(0, 255);
            if ($urandom_range(0, 1) == 0) begin
                send_op(KIND_FLUSH, PAGE_W'($urandom), FRAME_W'($urandom),
                    PAGE_W'($urandom), FRAME_W'($urandom));
            end
            repeat ($urandom_range(6, 20)) begin
                pg = PAGE_W'(pool_base + $urandom_range(0, 23));
                fr = FRAME_W'($urandom);
                send_op(KIND_FILL, pg, fr, PAGE_W'($urandom), FRAME_W'($urandom));
                remember_pair(pg, fr);
            end
            repeat ($urandom_range(20, 80)) begin
                roll = $urandom_range(0, 99);
                pr   = known_pairs[$urandom_range(0, known_pairs.size() - 1)];
                if (roll < 40) begin
                    roll = $urandom_range(0, 99);
                    pg   = (roll < 60) ? pr.page :
                           (roll < 85) ? PAGE_W'(pool_base + $urandom_range(0, 23)) :
                           PAGE_W'($urandom);
                    send_op(KIND_SEARCH, pg, FRAME_W'($urandom), PAGE_W'($urandom),
                        FRAME_W'($urandom));
                end else if (roll < 68) begin
                    pg = PAGE_W'(pool_base + $urandom_range(0, 23));
                    fr = FRAME_W'($urandom);
                    send_op(KIND_FILL, pg, fr, PAGE_W'($urandom), FRAME_W'($urandom));
                    remember_pair(pg, fr);
                end else if (roll < 84) begin
                    // mostly an exact old pair, sometimes one bit off
                    if ($urandom_range(0, 4) == 0) begin
                        if ($urandom_range(0, 1) == 0) begin
                            pr.page[$urandom_range(0, PAGE_W - 1)] ^= 1'b1;
                        end else begin
                            pr.frame[$urandom_range(0, FRAME_W - 1)] ^= 1'b1;
                        end
                    end
                    pg = PAGE_W'(pool_base + $urandom_range(0, 23));
                    fr = FRAME_W'($urandom);
                    send_op(KIND_REMAP, pg, fr, pr.page, pr.frame);
                    remember_pair(pg, fr);
                end else if (roll < 87) begin
                    send_op(KIND_FLUSH, PAGE_W'($urandom), FRAME_W'($urandom),
                        PAGE_W'($urandom), FRAME_W'($urandom));
                end else begin
                    send_op(t_kind'($urandom_range(0, 3)), PAGE_W'($urandom),
                        FRAME_W'($urandom), PAGE_W'($urandom), FRAME_W'($urandom));
                end
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk iff outstanding == 0);
        repeat (3 * ENTRIES) @(posedge i_clk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/fatlb_pkg.sv
design/fatlb_mem.sv
design/fully_assoc_tlb_pointer_replace_top.sv
design/fatlb_chk.sv
sim/tlb_translation_checker.sv
sim/tb_fully_assoc_tlb_pointer_replace_top.sv
